>>> src/bcle_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the bounded circular list engine.
// Has no dependencies; the engine and its testbench refer to it by scoped names.
package bcle_pkg;

    typedef enum logic [2:0] {
        OP_INS_START = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_START = 3'd3,
        OP_DEL_END   = 3'd4,
        OP_DEL_POS   = 3'd5,
        OP_READ_OUT  = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        t_op                op;
        logic        [7:0]  position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] element;
        logic               last;
        logic        [4:0]  length;
    } t_rsp;

endpackage

>>> src/bcle_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// No dependencies.
module bcle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bounded_circular_list_engine.sv
`timescale 1ns / 1ps
// Top level of the bounded circular list engine: sequencer, list registers and two node RAMs.
// Depends on bcle_pkg and bcle_ram.
//
// Requests enter on i_req with i_req_valid; o_req_stall is high while a request is in work.
// Results leave through an output register on o_rsp with o_rsp_valid; i_rsp_stall holds them.
// Each request gives one result, except a read-out of a non-empty list, which gives one result
// per element in list order with last set on the final one.
// The list is a circular chain in the link RAM; each request walks it from the head through the
// single read port of that RAM, one node per cycle. An insert or a delete walks at most the list
// length plus one nodes, then writes the links and loads its result into the output register;
// reusing a freed entry first pops it off the free chain. Inserting into an empty list or
// deleting its only node skips the walk, and a request answered at once with a status goes
// straight to its result. A read-out delivers one element per cycle while the receiver does
// not stall. Freed entries form a free chain through the same RAM, and never-used entries are
// handed out by a fill count, so reset needs no clearing pass. Reset empties the list at once.
// While the receiver stalls, the finished result stays in the output register; a read-out
// pauses in place and the next request is taken once the last result of the current one sits
// in the output register.
module bounded_circular_list_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  bcle_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_stall,
    output bcle_pkg::t_rsp  o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = LW + 1;
    localparam int MW = ((LW > 8) ? LW : 8) + 1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_POP   = 8'b0000_0010,
        S_POPD  = 8'b0000_0100,
        S_WALK  = 8'b0000_1000,
        S_FIX1  = 8'b0001_0000,
        S_FIX2  = 8'b0010_0000,
        S_RDOUT = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [LW-1:0]     r_len, n_len;
    logic [LW-1:0]     r_fill, n_fill;
    logic [AW-1:0]     r_free_head, n_free_head;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_is_ins, n_is_ins;
    logic              r_kzero, n_kzero;
    logic              r_single, n_single;
    logic              r_use_rdata, n_use_rdata;
    logic [AW-1:0]     r_p, n_p;
    logic [AW-1:0]     r_pp, n_pp;
    logic [AW-1:0]     r_new, n_new;
    bcle_pkg::t_status r_status, n_status;
    logic [DATA_WIDTH-1:0] r_value;
    logic              r_out_valid, n_out_valid;
    bcle_pkg::t_rsp    r_out;

    logic                  nx_we, nx_re, dt_we, dt_re;
    logic [AW-1:0]         nx_waddr, nx_wdata, nx_raddr, dt_raddr;
    logic [AW-1:0]         nx_rdata;
    logic [DATA_WIDTH-1:0] dt_rdata;

    logic                  acc, out_free, ld;
    bcle_pkg::t_rsp        ld_rsp;
    logic                  is_ins_op, bad_pos, full, empty, free_avail;
    logic [MW-1:0]         pos_w, len_w, pm1;
    logic [LW-1:0]         k_idx, t_idx;
    logic [CW-1:0]         walk_cnt;
    logic [AW-1:0]         cur;
    logic signed [63:0]    v_ext;
    logic [63:0]           d_ext;
    logic [31:0]           len_ext;

    bcle_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_re    (nx_re),
        .i_raddr (nx_raddr),
        .o_rdata (nx_rdata)
    );

    bcle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (dt_we),
        .i_waddr (r_new),
        .i_wdata (r_value),
        .i_re    (dt_re),
        .i_raddr (dt_raddr),
        .o_rdata (dt_rdata)
    );

    assign o_req_stall = (r_state != S_IDLE);
    assign acc         = i_req_valid && !o_req_stall;
    assign out_free    = !r_out_valid || !i_rsp_stall;

    assign is_ins_op  = (i_req.op == bcle_pkg::OP_INS_START) ||
                        (i_req.op == bcle_pkg::OP_INS_END) ||
                        (i_req.op == bcle_pkg::OP_INS_POS);
    assign full       = (r_len == LW'(DEPTH));
    assign empty      = (r_len == '0);
    assign free_avail = (r_fill != r_len);
    assign pos_w      = MW'(i_req.position);
    assign len_w      = MW'(r_len);
    assign pm1        = pos_w - MW'(1);
    assign bad_pos    = (pos_w == '0) || (pos_w > len_w);

    always_comb begin
        case (i_req.op)
            bcle_pkg::OP_INS_END: k_idx = r_len;
            bcle_pkg::OP_INS_POS: begin
                if (pos_w <= MW'(1)) begin
                    k_idx = '0;
                end else if (pm1 > len_w) begin
                    k_idx = r_len;
                end else begin
                    k_idx = LW'(pm1);
                end
            end
            bcle_pkg::OP_DEL_END: k_idx = r_len - LW'(1);
            bcle_pkg::OP_DEL_POS: k_idx = LW'(pm1);
            default:              k_idx = '0;
        endcase
    end

    assign t_idx    = (k_idx == '0) ? (r_len - LW'(1)) : (k_idx - LW'(1));
    assign walk_cnt = CW'(t_idx) + (is_ins_op ? CW'(1) : CW'(2));
    assign cur      = r_use_rdata ? nx_rdata : r_head;
    assign v_ext    = 64'(i_req.value);
    assign d_ext    = 64'(dt_rdata);
    assign len_ext  = 32'(r_len);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_len       = r_len;
        n_fill      = r_fill;
        n_free_head = r_free_head;
        n_cnt       = r_cnt;
        n_is_ins    = r_is_ins;
        n_kzero     = r_kzero;
        n_single    = r_single;
        n_use_rdata = r_use_rdata;
        n_p         = r_p;
        n_pp        = r_pp;
        n_new       = r_new;
        n_status    = r_status;
        nx_we       = 1'b0;
        nx_waddr    = r_p;
        nx_wdata    = r_new;
        nx_re       = 1'b0;
        nx_raddr    = r_head;
        dt_we       = 1'b0;
        dt_re       = 1'b0;
        dt_raddr    = r_head;
        ld          = 1'b0;
        ld_rsp      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_status    = bcle_pkg::ST_OK;
                    n_is_ins    = is_ins_op;
                    n_kzero     = (k_idx == '0);
                    n_cnt       = walk_cnt;
                    n_use_rdata = 1'b0;
                    unique case (i_req.op) inside
                        bcle_pkg::OP_INS_START, bcle_pkg::OP_INS_END,
                        bcle_pkg::OP_INS_POS: begin
                            n_single = empty;
                            if (full) begin
                                n_status = bcle_pkg::ST_FULL;
                                n_state  = S_RESP;
                            end else if (free_avail) begin
                                n_new   = r_free_head;
                                n_state = S_POP;
                            end else begin
                                n_new   = AW'(r_fill);
                                n_fill  = r_fill + LW'(1);
                                n_state = empty ? S_FIX1 : S_WALK;
                            end
                        end
                        bcle_pkg::OP_DEL_START, bcle_pkg::OP_DEL_END,
                        bcle_pkg::OP_DEL_POS: begin
                            n_single = (r_len == LW'(1));
                            if (empty) begin
                                n_status = bcle_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else if (i_req.op == bcle_pkg::OP_DEL_POS && bad_pos) begin
                                n_status = bcle_pkg::ST_BADPOS;
                                n_state  = S_RESP;
                            end else begin
                                n_state = (r_len == LW'(1)) ? S_FIX1 : S_WALK;
                            end
                        end
                        bcle_pkg::OP_READ_OUT: begin
                            if (empty) begin
                                n_status = bcle_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                nx_re   = 1'b1;
                                dt_re   = 1'b1;
                                n_cnt   = CW'(r_len);
                                n_state = S_RDOUT;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_POP: begin
                nx_re    = 1'b1;
                nx_raddr = r_free_head;
                n_state  = S_POPD;
            end
            S_POPD: begin
                n_free_head = nx_rdata;
                n_state     = r_single ? S_FIX1 : S_WALK;
            end
            S_WALK: begin
                nx_re       = 1'b1;
                nx_raddr    = cur;
                n_pp        = r_p;
                n_p         = cur;
                n_use_rdata = 1'b1;
                n_cnt       = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = S_FIX1;
                end
            end
            S_FIX1: begin
                nx_we = 1'b1;
                if (r_is_ins) begin
                    dt_we    = 1'b1;
                    nx_waddr = r_new;
                    if (r_single) begin
                        nx_wdata = r_new;
                        n_head   = r_new;
                        n_len    = r_len + LW'(1);
                        n_state  = S_RESP;
                    end else begin
                        nx_wdata = nx_rdata;
                        n_state  = S_FIX2;
                    end
                end else if (r_single) begin
                    nx_waddr    = r_head;
                    nx_wdata    = r_free_head;
                    n_free_head = r_head;
                    n_len       = '0;
                    n_state     = S_RESP;
                end else begin
                    nx_waddr = r_pp;
                    nx_wdata = nx_rdata;
                    if (r_kzero) begin
                        n_head = nx_rdata;
                    end
                    n_state = S_FIX2;
                end
            end
            S_FIX2: begin
                nx_we    = 1'b1;
                nx_waddr = r_p;
                if (r_is_ins) begin
                    nx_wdata = r_new;
                    if (r_kzero) begin
                        n_head = r_new;
                    end
                    n_len = r_len + LW'(1);
                end else begin
                    nx_wdata    = r_free_head;
                    n_free_head = r_p;
                    n_len       = r_len - LW'(1);
                end
                n_state = S_RESP;
            end
            S_RDOUT: begin
                if (out_free) begin
                    ld             = 1'b1;
                    ld_rsp.status  = bcle_pkg::ST_OK;
                    ld_rsp.element = d_ext[31:0];
                    ld_rsp.last    = (r_cnt == CW'(1));
                    ld_rsp.length  = len_ext[4:0];
                    if (r_cnt == CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        nx_re    = 1'b1;
                        dt_re    = 1'b1;
                        nx_raddr = nx_rdata;
                        dt_raddr = nx_rdata;
                        n_cnt    = r_cnt - CW'(1);
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    ld            = 1'b1;
                    ld_rsp.status = r_status;
                    ld_rsp.last   = 1'b1;
                    ld_rsp.length = len_ext[4:0];
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = ld || (r_out_valid && i_rsp_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_len       <= '0;
            r_fill      <= '0;
            r_free_head <= '0;
            r_cnt       <= '0;
            r_is_ins    <= 1'b0;
            r_kzero     <= 1'b0;
            r_single    <= 1'b0;
            r_use_rdata <= 1'b0;
            r_p         <= '0;
            r_pp        <= '0;
            r_new       <= '0;
            r_status    <= bcle_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_len       <= n_len;
            r_fill      <= n_fill;
            r_free_head <= n_free_head;
            r_cnt       <= n_cnt;
            r_is_ins    <= n_is_ins;
            r_kzero     <= n_kzero;
            r_single    <= n_single;
            r_use_rdata <= n_use_rdata;
            r_p         <= n_p;
            r_pp        <= n_pp;
            r_new       <= n_new;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_value <= v_ext[DATA_WIDTH-1:0];
        end
        if (ld) begin
            r_out <= ld_rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(DEPTH))
        else $error("List length exceeds the node store depth.");

    a_fill_covers_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill >= r_len)
        else $error("Fill count fell below the list length.");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> o_req_stall)
        else $error("A new request was taken before the previous one started.");

    a_readout_holds_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDOUT && !out_free) |=> $stable(nx_rdata))
        else $error("Read-out lost its place while the receiver stalled.");
`endif

endmodule

>>> dv/tb_bounded_circular_list_engine.sv
`timescale 1ns / 1ps
// Self-checking testbench for bounded_circular_list_engine: directed list edge cases, then
// random grow and shrink traffic with idling on both sides and a long receiver hold-off.
// Depends on bcle_pkg and the engine RTL; it keeps its own list model to predict results.
module tb_bounded_circular_list_engine;

    localparam int          LIST_DEPTH   = 16;
    localparam logic [2:0]  OP_UNDEFINED = 3'd7;
    localparam int unsigned DRAIN_LIMIT  = 50000;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_req_valid;
    logic           o_req_stall;
    bcle_pkg::t_req i_req;
    logic           o_rsp_valid;
    logic           i_rsp_stall;
    bcle_pkg::t_rsp o_rsp;

    logic signed [31:0] list_model[$];
    bcle_pkg::t_rsp     expected_rsps[$];

    bit          req_idle_on = 1'b1;
    bit          rsp_idle_on = 1'b1;
    int unsigned hold_off_len = 0;
    int unsigned requests_sent = 0;
    int unsigned results_checked = 0;
    int unsigned fail_count = 0;
    int unsigned elements_seen = 0;
    int unsigned full_seen = 0;
    int unsigned empty_seen = 0;
    int unsigned badpos_seen = 0;

    bounded_circular_list_engine #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (32)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic void push_rsp(input bcle_pkg::t_status st,
                                     input logic signed [31:0] elem, input logic lst);
        bcle_pkg::t_rsp r;
        r.status  = st;
        r.element = elem;
        r.last    = lst;
        r.length  = 5'(list_model.size());
        expected_rsps.push_back(r);
    endfunction

    // Applies one accepted request to the list model and queues the results it causes.
    function automatic void predict_list_request(input bcle_pkg::t_req req);
        int                len;
        int                idx;
        bcle_pkg::t_status st;
        len = list_model.size();
        st  = bcle_pkg::ST_OK;
        case (req.op)
            bcle_pkg::OP_INS_START, bcle_pkg::OP_INS_END, bcle_pkg::OP_INS_POS: begin
                if (req.op == bcle_pkg::OP_INS_START) begin
                    idx = 0;
                end else if (req.op == bcle_pkg::OP_INS_END) begin
                    idx = len;
                end else begin
                    idx = (req.position <= 1) ? 0 : int'(req.position) - 1;
                    if (idx > len) idx = len;
                end
                if (len >= LIST_DEPTH) begin
                    st = bcle_pkg::ST_FULL;
                end else begin
                    list_model.insert(idx, req.value);
                end
            end
            bcle_pkg::OP_DEL_START, bcle_pkg::OP_DEL_END: begin
                if (len == 0) begin
                    st = bcle_pkg::ST_EMPTY;
                end else begin
                    list_model.delete((req.op == bcle_pkg::OP_DEL_START) ? 0 : len - 1);
                end
            end
            bcle_pkg::OP_DEL_POS: begin
                if (len == 0) begin
                    st = bcle_pkg::ST_EMPTY;
                end else if (req.position == 0 || int'(req.position) > len) begin
                    st = bcle_pkg::ST_BADPOS;
                end else begin
                    list_model.delete(int'(req.position) - 1);
                end
            end
            bcle_pkg::OP_READ_OUT: begin
                if (len == 0) begin
                    st = bcle_pkg::ST_EMPTY;
                end else begin
                    foreach (list_model[k]) begin
                        push_rsp(bcle_pkg::ST_OK, list_model[k], k == len - 1);
                    end
                    return;
                end
            end
            default: begin
            end
        endcase
        push_rsp(st, '0, 1'b1);
    endfunction

    // Offers one request and returns once it has been taken, leaving valid high.
    task automatic send_request(input logic [2:0] op, input logic [7:0] pos,
                                input logic signed [31:0] val);
        bcle_pkg::t_req req;
        req.op       = bcle_pkg::t_op'(op);
        req.position = pos;
        req.value    = val;
        if (req_idle_on && $urandom_range(0, 4) == 0) begin
            i_req_valid <= 1'b0;
            i_req       <= bcle_pkg::t_req'($bits(bcle_pkg::t_req)'({$urandom, $urandom}));
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= req;
        do begin
            @(posedge i_clk);
        end while (o_req_stall);
        predict_list_request(req);
        requests_sent++;
    endtask

    task automatic send_random_request(input int unsigned insert_pct);
        int unsigned        roll;
        int unsigned        len;
        logic [2:0]         op;
        logic [7:0]         pos;
        logic signed [31:0] val;
        len  = list_model.size();
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            op = OP_UNDEFINED;
        end else if (roll < 10) begin
            op = bcle_pkg::OP_READ_OUT;
        end else if (roll < 10 + insert_pct * 90 / 100) begin
            op = 3'($urandom_range(bcle_pkg::OP_INS_START, bcle_pkg::OP_INS_POS));
        end else begin
            op = 3'($urandom_range(bcle_pkg::OP_DEL_START, bcle_pkg::OP_DEL_POS));
        end
        if ($urandom_range(0, 3) == 0) begin
            pos = 8'($urandom_range(0, 255));
        end else begin
            pos = 8'($urandom_range(0, len + 2));
        end
        case ($urandom_range(0, 7))
            0:       val = 32'sh7FFF_FFFF;
            1:       val = 32'sh8000_0000;
            default: val = $urandom;
        endcase
        send_request(op, pos, val);
    endtask

    task automatic test_empty_list_cases();
        send_request(bcle_pkg::OP_READ_OUT, 8'd0, 32'sd0);
        send_request(bcle_pkg::OP_DEL_START, 8'd1, 32'sd0);
        send_request(bcle_pkg::OP_DEL_END, 8'd1, 32'sd0);
        send_request(bcle_pkg::OP_DEL_POS, 8'd1, 32'sd0);
        send_request(OP_UNDEFINED, 8'hFF, 32'shFFFF_FFFF);
    endtask

    task automatic test_insert_positions();
        send_request(bcle_pkg::OP_INS_POS, 8'd5, 32'sh1234_5678);
        send_request(bcle_pkg::OP_INS_START, 8'd0, 32'sh7FFF_FFFF);
        send_request(bcle_pkg::OP_INS_END, 8'd0, 32'sh8000_0000);
        send_request(bcle_pkg::OP_INS_POS, 8'd0, 32'sd0);
        send_request(bcle_pkg::OP_INS_POS, 8'd1, -32'sd1);
        send_request(bcle_pkg::OP_INS_POS, 8'hFF, 32'shAAAA_AAAA);
        send_request(bcle_pkg::OP_INS_POS, 8'd3, 32'sh5555_5555);
        send_request(bcle_pkg::OP_READ_OUT, 8'd0, 32'sd0);
    endtask

    task automatic test_delete_positions();
        send_request(bcle_pkg::OP_DEL_POS, 8'd0, 32'sd0);
        send_request(bcle_pkg::OP_DEL_POS, 8'hFF, 32'sd0);
        send_request(bcle_pkg::OP_DEL_POS, 8'(list_model.size() + 1), 32'sd0);
        send_request(bcle_pkg::OP_DEL_POS, 8'(list_model.size()), 32'sd0);
        send_request(bcle_pkg::OP_DEL_POS, 8'd2, 32'sd0);
        send_request(bcle_pkg::OP_DEL_START, 8'd0, 32'sd0);
        send_request(bcle_pkg::OP_DEL_END, 8'd0, 32'sd0);
        send_request(OP_UNDEFINED, 8'd0, 32'sd0);
        send_request(bcle_pkg::OP_READ_OUT, 8'd0, 32'sd0);
    endtask

    // Alternating insert-heavy and delete-heavy stretches drive the list to full and to empty.
    task automatic test_random_grow_shrink();
        for (int phase = 0; phase < 4; phase++) begin
            repeat (35) send_random_request((phase % 2 == 0) ? 80 : 20);
        end
    endtask

    task automatic test_receiver_hold_off();
        req_idle_on  = 1'b0;
        hold_off_len = 300;
        repeat (15) send_random_request(70);
        req_idle_on  = 1'b1;
    endtask

    task automatic test_no_idle_tail();
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        repeat (20) send_random_request(85);
        repeat (20) send_random_request(15);
    endtask

    initial begin : rsp_stall_proc
        int unsigned n;
        i_rsp_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_len != 0) begin
                n            = hold_off_len;
                hold_off_len = 0;
                i_rsp_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_rsp_stall <= 1'b0;
            end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
                i_rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : rsp_check
        bcle_pkg::t_rsp want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            case (o_rsp.status)
                bcle_pkg::ST_FULL:   full_seen++;
                bcle_pkg::ST_EMPTY:  empty_seen++;
                bcle_pkg::ST_BADPOS: badpos_seen++;
                default:             if (o_rsp.element != 0 || !o_rsp.last) elements_seen++;
            endcase
            if (expected_rsps.size() == 0) begin
                note_failure($sformatf(
                    "unexpected result status %0d element %0d last %0b length %0d",
                    o_rsp.status, o_rsp.element, o_rsp.last, o_rsp.length));
            end else begin
                want = expected_rsps.pop_front();
                results_checked++;
                if (o_rsp.status !== want.status || o_rsp.element !== want.element ||
                    o_rsp.last !== want.last || o_rsp.length !== want.length) begin
                    note_failure($sformatf({"result %0d: expected status %0d element %0d ",
                                            "last %0b length %0d, got status %0d element %0d ",
                                            "last %0b length %0d"},
                                           results_checked, want.status, want.element,
                                           want.last, want.length, o_rsp.status,
                                           o_rsp.element, o_rsp.last, o_rsp.length));
                end
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("bounded_circular_list_engine regression: fail");
        $finish;
    end

    initial begin : main_seq
        int unsigned waited;
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list_cases();
        test_insert_positions();
        test_delete_positions();
        test_random_grow_shrink();
        test_receiver_hold_off();
        test_no_idle_tail();
        i_req_valid <= 1'b0;

        waited = 0;
        while (expected_rsps.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (expected_rsps.size() != 0) begin
            note_failure($sformatf("%0d expected results never arrived", expected_rsps.size()));
        end

        $display("Sent %0d requests and checked %0d results, %0d of them read-out elements.",
                 requests_sent, results_checked, elements_seen);
        $display("Answers seen: %0d store full, %0d list empty, %0d bad position; %0d failures.",
                 full_seen, empty_seen, badpos_seen, fail_count);
        if (fail_count == 0) begin
            $display("bounded_circular_list_engine regression: pass");
        end else begin
            $display("bounded_circular_list_engine regression: fail");
        end
        $finish;
    end

endmodule
